/* hdl/pidpwm_pkg.sv */
// ----------------------------------------------------------------------------
// pidpwm_pkg
// Shared types, codes and constants of the PID angle controller with PWM.
// ----------------------------------------------------------------------------
package pidpwm_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_ILIM  = 3'd3;
  localparam logic [2:0] REG_ALIM  = 3'd4;
  localparam logic [2:0] REG_ZERO  = 3'd5;
  localparam logic [2:0] REG_AREF  = 3'd6;

  // Register reset values.
  localparam logic [15:0] KP_RST   = 16'd11520;
  localparam logic [15:0] KI_RST   = 16'd282;
  localparam logic [15:0] KD_RST   = 16'd17920;
  localparam logic [15:0] ILIM_RST = 16'd45056;
  localparam logic [13:0] ALIM_RST = 14'd6144;
  localparam logic [15:0] ZERO_RST = 16'd4000;
  localparam logic [14:0] AREF_RST = 15'd0;

  // Counts to Q4.12 radians: pi*2^12/4000 scaled by 2^11.
  localparam int unsigned ANGLE_SCALE = 6588;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD_IN  = 4'd1;
  localparam logic [3:0] OP_MUL_ANG  = 4'd2;
  localparam logic [3:0] OP_CHECK    = 4'd3;
  localparam logic [3:0] OP_MUL_P    = 4'd4;
  localparam logic [3:0] OP_MUL_I    = 4'd5;
  localparam logic [3:0] OP_MUL_D    = 4'd6;
  localparam logic [3:0] OP_SUM      = 4'd7;
  localparam logic [3:0] OP_MUL_DUTY = 4'd8;
  localparam logic [3:0] OP_OUT      = 4'd9;

  // Kind of result being produced.
  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [15:0] ilim;
    logic [13:0] alim;
    logic [15:0] zero;
    logic [14:0] aref;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic start_req;
    logic go;
    logic out_free;
  } sts_t;

endpackage

/* hdl/pidpwm_cfg.sv */
// ----------------------------------------------------------------------------
// pidpwm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pidpwm_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output pidpwm_pkg::cfg_t   cfg
);

  pidpwm_pkg::cfg_t cfg_r;
  pidpwm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pidpwm_pkg::REG_KP:   cfg_nxt.kp   = cfg_wdata;
        pidpwm_pkg::REG_KI:   cfg_nxt.ki   = cfg_wdata;
        pidpwm_pkg::REG_KD:   cfg_nxt.kd   = cfg_wdata;
        pidpwm_pkg::REG_ILIM: cfg_nxt.ilim = cfg_wdata;
        pidpwm_pkg::REG_ALIM: cfg_nxt.alim = cfg_wdata[13:0];
        pidpwm_pkg::REG_ZERO: cfg_nxt.zero = cfg_wdata;
        pidpwm_pkg::REG_AREF: cfg_nxt.aref = cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp   <= pidpwm_pkg::KP_RST;
      cfg_r.ki   <= pidpwm_pkg::KI_RST;
      cfg_r.kd   <= pidpwm_pkg::KD_RST;
      cfg_r.ilim <= pidpwm_pkg::ILIM_RST;
      cfg_r.alim <= pidpwm_pkg::ALIM_RST;
      cfg_r.zero <= pidpwm_pkg::ZERO_RST;
      cfg_r.aref <= pidpwm_pkg::AREF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/pidpwm_ctrl.sv */
// ----------------------------------------------------------------------------
// pidpwm_ctrl
// Sequencer that steps the shared multiplier through one control word.
// ----------------------------------------------------------------------------
module pidpwm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  pidpwm_pkg::sts_t   sts,
  output pidpwm_pkg::cmd_t   cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ANG  = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_MP   = 4'd3;
  localparam logic [3:0] ST_MI   = 4'd4;
  localparam logic [3:0] ST_MD   = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_DUTY = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd.op    = pidpwm_pkg::OP_NONE;
    cmd.kind  = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = pidpwm_pkg::OP_LOAD_IN;
          state_nxt = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd.op = pidpwm_pkg::OP_MUL_ANG;
        if (sts.start_req) begin
          kind_nxt  = pidpwm_pkg::KIND_START;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.op = pidpwm_pkg::OP_CHECK;
        if (sts.go) begin
          kind_nxt  = pidpwm_pkg::KIND_RUN;
          state_nxt = ST_MP;
        end else begin
          kind_nxt  = pidpwm_pkg::KIND_STOP;
          state_nxt = ST_OUT;
        end
      end
      ST_MP: begin
        cmd.op    = pidpwm_pkg::OP_MUL_P;
        state_nxt = ST_MI;
      end
      ST_MI: begin
        cmd.op    = pidpwm_pkg::OP_MUL_I;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        cmd.op    = pidpwm_pkg::OP_MUL_D;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = pidpwm_pkg::OP_SUM;
        state_nxt = ST_DUTY;
      end
      ST_DUTY: begin
        cmd.op    = pidpwm_pkg::OP_MUL_DUTY;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op    = pidpwm_pkg::OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= pidpwm_pkg::KIND_RUN;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

/* hdl/pidpwm_dp.sv */
// ----------------------------------------------------------------------------
// pidpwm_dp
// Datapath: shared multiplier, PID state, saturation and the output register.
// ----------------------------------------------------------------------------
module pidpwm_dp #(
  parameter int unsigned PWM_TOP = 999
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pidpwm_pkg::cmd_t   cmd,
  output pidpwm_pkg::sts_t   sts,
  input  pidpwm_pkg::cfg_t   cfg,
  input  logic               in_func,
  input  logic [15:0]        in_count,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [39:0]        out_tdata
);

  localparam int unsigned DUTY_SCALE = ((PWM_TOP + 1) * 1024) / 12;
  localparam int unsigned SCALE_W    = $clog2(DUTY_SCALE + 1);
  localparam int unsigned MB_W       = ((SCALE_W > 16) ? SCALE_W : 16) + 1;
  localparam int unsigned MA_W       = 21;
  localparam int unsigned P_W        = MA_W + MB_W;
  localparam int unsigned DUTY_W     = P_W - 22;

  // Input latch.
  logic        func_r;
  logic [15:0] count_r;

  // Shared multiplier.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod_r;

  // PID state and intermediates.
  logic              enable_r;
  logic signed [17:0] isum_r;
  logic signed [16:0] prev_r;
  logic signed [19:0] held_r;
  logic signed [16:0] err_r;
  logic signed [25:0] pk_r;
  logic signed [17:0] ik_r;
  logic signed [19:0] drive_r;

  // Output register.
  logic               out_valid_r;
  logic [9:0]         o_duty_r;
  logic               o_fwd_r, o_rev_r, o_en_r;
  logic signed [19:0] o_drive_r;

  logic signed [16:0] diff;
  logic signed [16:0] dlt;
  logic signed [17:0] dlt_w;
  logic signed [18:0] angle;
  logic        [18:0] mag;
  logic signed [16:0] err_nxt;
  logic signed [P_W-1:0] rnd_sum;
  logic signed [25:0] rnd_q;
  logic signed [26:0] ik_sum;
  logic signed [26:0] ilim_p, ilim_n;
  logic signed [17:0] ik_nxt;
  logic signed [27:0] drv_sum;
  logic signed [19:0] drive_nxt;
  logic        [20:0] abs_drive;
  logic        [P_W-1:0] duty_sum;
  logic        [DUTY_W-1:0] duty_full, duty_cap;

  assign diff    = $signed({1'b0, count_r}) - $signed({1'b0, cfg.zero});
  assign dlt_w   = {err_r[16], err_r} - {prev_r[16], prev_r};
  assign dlt     = dlt_w[16:0];
  assign abs_drive = drive_r[19] ? (21'd0 - {drive_r[19], drive_r})
                                 : {drive_r[19], drive_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pidpwm_pkg::OP_MUL_ANG: begin
        mul_a = {{(MA_W-17){diff[16]}}, diff};
        mul_b = MB_W'(pidpwm_pkg::ANGLE_SCALE);
      end
      pidpwm_pkg::OP_MUL_P: begin
        mul_a = {{(MA_W-17){err_r[16]}}, err_r};
        mul_b = {{(MB_W-16){1'b0}}, cfg.kp};
      end
      pidpwm_pkg::OP_MUL_I: begin
        mul_a = {{(MA_W-17){err_r[16]}}, err_r};
        mul_b = {{(MB_W-16){1'b0}}, cfg.ki};
      end
      pidpwm_pkg::OP_MUL_D: begin
        mul_a = {{(MA_W-17){dlt[16]}}, dlt};
        mul_b = {{(MB_W-16){1'b0}}, cfg.kd};
      end
      pidpwm_pkg::OP_MUL_DUTY: begin
        mul_a = abs_drive;
        mul_b = MB_W'(DUTY_SCALE);
      end
      default: ;
    endcase
  end

  // Angle check, from the angle product.
  assign angle   = prod_r[29:11];
  assign mag     = angle[18] ? (19'd0 - angle) : angle;
  assign err_nxt = {{2{cfg.aref[14]}}, cfg.aref} - angle[16:0];

  // Round half up of a Q4.12 x Q8.8 product back to Q4.12.
  assign rnd_sum = prod_r + $signed(P_W'(128));
  assign rnd_q   = rnd_sum[33:8];

  // Integral with clamp.
  assign ik_sum = {rnd_q[25], rnd_q} + {{9{isum_r[17]}}, isum_r};
  assign ilim_p = {11'd0, cfg.ilim};
  assign ilim_n = 27'd0 - {11'd0, cfg.ilim};
  always_comb begin
    if (ik_sum > ilim_p) begin
      ik_nxt = ilim_p[17:0];
    end else if (ik_sum < ilim_n) begin
      ik_nxt = ilim_n[17:0];
    end else begin
      ik_nxt = ik_sum[17:0];
    end
  end

  // Total drive with saturation to the 20-bit range.
  assign drv_sum = {{2{pk_r[25]}}, pk_r} + {{10{ik_r[17]}}, ik_r}
                 + {{2{rnd_q[25]}}, rnd_q};
  always_comb begin
    if (drv_sum > 28'sd524287) begin
      drive_nxt = 20'sh7FFFF;
    end else if (drv_sum < -28'sd524288) begin
      drive_nxt = 20'sh80000;
    end else begin
      drive_nxt = drv_sum[19:0];
    end
  end

  // Duty from the duty product.
  assign duty_sum  = prod_r + P_W'(22'h200000);
  assign duty_full = duty_sum[P_W-1:22];
  assign duty_cap  = (duty_full > DUTY_W'(PWM_TOP)) ? DUTY_W'(PWM_TOP) : duty_full;

  always_ff @(posedge clk) begin
    if (cmd.op == pidpwm_pkg::OP_LOAD_IN) begin
      func_r  <= in_func;
      count_r <= in_count;
    end
    if (cmd.op == pidpwm_pkg::OP_MUL_ANG || cmd.op == pidpwm_pkg::OP_MUL_P ||
        cmd.op == pidpwm_pkg::OP_MUL_I   || cmd.op == pidpwm_pkg::OP_MUL_D ||
        cmd.op == pidpwm_pkg::OP_MUL_DUTY) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.op == pidpwm_pkg::OP_CHECK) begin
      err_r <= err_nxt;
    end
    if (cmd.op == pidpwm_pkg::OP_MUL_I) begin
      pk_r <= rnd_q;
    end
    if (cmd.op == pidpwm_pkg::OP_MUL_D) begin
      ik_r <= ik_nxt;
    end
    if (cmd.op == pidpwm_pkg::OP_SUM) begin
      drive_r <= drive_nxt;
    end
    if (cmd.op == pidpwm_pkg::OP_OUT) begin
      unique case (cmd.kind)
        pidpwm_pkg::KIND_START: begin
          o_duty_r  <= '0;
          o_fwd_r   <= 1'b0;
          o_rev_r   <= 1'b0;
          o_en_r    <= 1'b1;
          o_drive_r <= held_r;
        end
        pidpwm_pkg::KIND_RUN: begin
          o_duty_r  <= duty_cap[9:0];
          o_fwd_r   <= ~drive_r[19];
          o_rev_r   <= drive_r[19];
          o_en_r    <= 1'b1;
          o_drive_r <= drive_r;
        end
        default: begin
          o_duty_r  <= '0;
          o_fwd_r   <= 1'b0;
          o_rev_r   <= 1'b0;
          o_en_r    <= 1'b0;
          o_drive_r <= '0;
        end
      endcase
    end
  end

  // Controller state and handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      isum_r      <= '0;
      prev_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == pidpwm_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
        unique case (cmd.kind)
          pidpwm_pkg::KIND_START: enable_r <= 1'b1;
          pidpwm_pkg::KIND_RUN: begin
            isum_r <= ik_r;
            prev_r <= err_r;
            held_r <= drive_r;
          end
          default: begin
            enable_r <= 1'b0;
            held_r   <= '0;
          end
        endcase
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.start_req = func_r;
  assign sts.go        = enable_r && (mag < {5'd0, cfg.alim});
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_drive_r, o_en_r, o_rev_r, o_fwd_r, o_duty_r};

endmodule

/* hdl/pid_angle_controller_pwm_top.sv */
// Sequence: load, angle product, range check, P, I, D, sum, duty, output. A start
// request skips from angle to output; a disabled or out-of-range tick, from the check.
// Words are processed one at a time, set by the single shared multiplier
// that the sequencer steps through angle, P, I, D and duty products.
// A new word is accepted while the previous result waits in the output register.
// Reset (rst_n, synchronous, active low) restores register defaults and
// clears the enable flag, integral, previous error and held drive.
// ----------------------------------------------------------------------------
// pid_angle_controller_pwm_top
// PID angle controller with integral clamp driving an H-bridge PWM.
// ----------------------------------------------------------------------------
module pid_angle_controller_pwm_top #(
  parameter int unsigned PWM_TOP = 999
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] encoder_count
  input  logic        in_tuser,   // [0] func: 0 control tick, 1 start request
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [9:0] pwm_duty, [10] dir_forward,
                                  // [11] dir_reverse, [12] enabled,
                                  // [32:13] drive_volts, [39:33] zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers: gains, limits, encoder zero, angle reference. The user
  // must see that they are only written while no word is in flight; the block trusts it.
  pidpwm_pkg::cfg_t cfg;

  // The sequencer issues one datapath operation per cycle unless it waits for
  // input or a free output register; the datapath reports back the start flag,
  // the in-range decision and whether the output register can take a new word.
  pidpwm_pkg::cmd_t cmd;
  pidpwm_pkg::sts_t sts;

  pidpwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath shares one signed multiplier among all products, rounds
  // each gain product half up, clamps the integral and saturates the drive
  // before scaling its magnitude to a PWM compare value.
  pidpwm_dp #(
    .PWM_TOP (PWM_TOP)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_func    (in_tuser),
    .in_count   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/pidpwm_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpwm_check_pkg
// Expected-result tracking for the PID angle controller: the result layout,
// stimulus codes and a class that follows the controller state word by word.
// ----------------------------------------------------------------------------
package pidpwm_check_pkg;

  import pidpwm_pkg::*;

  // Function codes carried in tuser.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // Register index with no register behind it; writes to it are dropped.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam longint PWM_TOP    = 999;
  localparam longint DUTY_SCALE = ((PWM_TOP + 1) * 1024) / 12;
  localparam longint DRIVE_MAX  = 524287;
  localparam longint DRIVE_MIN  = -524288;

  // Result word, lowest field last.
  typedef struct packed {
    logic [6:0]         pad;
    logic signed [19:0] drive;
    logic               enabled;
    logic               dir_rev;
    logic               dir_fwd;
    logic [9:0]         duty;
  } drive_word_t;

  class pid_drive_tracker;
    cfg_t        regs;
    bit          enable_flag;
    longint      integral_sum;
    longint      previous_error;
    longint      held_drive;
    drive_word_t awaited_results[$];
    int          errors;

    function new();
      regs = '{kp: KP_RST, ki: KI_RST, kd: KD_RST, ilim: ILIM_RST,
               alim: ALIM_RST, zero: ZERO_RST, aref: AREF_RST};
      enable_flag    = 1'b0;
      integral_sum   = 0;
      previous_error = 0;
      held_drive     = 0;
      errors         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_KP:   regs.kp = data;
        REG_KI:   regs.ki = data;
        REG_KD:   regs.kd = data;
        REG_ILIM: regs.ilim = data;
        REG_ALIM: regs.alim = data[13:0];
        REG_ZERO: regs.zero = data;
        REG_AREF: regs.aref = data[14:0];
        default: ;
      endcase
    endfunction

    // Q4.12 times Q8.8 gain, rounded half up back to Q4.12.
    function longint gain_product(longint x, logic [15:0] g);
      return (x * longint'(g) + 128) >>> 8;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // Advance the controller state for one accepted input word.
    function void note_word(logic func, logic [15:0] count);
      drive_word_t r;
      longint angle, mag, err, ik, dk, pk, mk, absd, duty;
      r = '0;
      if (func == FUNC_START) begin
        enable_flag = 1'b1;
        r.enabled   = 1'b1;
        r.drive     = held_drive[19:0];
      end else begin
        angle = ((longint'(count) - longint'(regs.zero)) * longint'(ANGLE_SCALE)) >>> 11;
        mag   = (angle < 0) ? -angle : angle;
        if (!enable_flag || mag >= longint'(regs.alim)) begin
          enable_flag = 1'b0;
          held_drive  = 0;
        end else begin
          err = longint'($signed(regs.aref)) - angle;
          ik  = clip(gain_product(err, regs.ki) + integral_sum,
                     -longint'(regs.ilim), longint'(regs.ilim));
          dk  = gain_product(err - previous_error, regs.kd);
          pk  = gain_product(err, regs.kp);
          mk  = clip(pk + ik + dk, DRIVE_MIN, DRIVE_MAX);
          integral_sum   = ik;
          previous_error = err;
          held_drive     = mk;
          absd = (mk < 0) ? -mk : mk;
          duty = (absd * DUTY_SCALE + (longint'(1) << 21)) >>> 22;
          if (duty > PWM_TOP) duty = PWM_TOP;
          r.duty    = duty[9:0];
          r.dir_fwd = (mk >= 0);
          r.dir_rev = (mk < 0);
          r.enabled = 1'b1;
          r.drive   = mk[19:0];
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_word(logic [39:0] data);
      drive_word_t got, want;
      got = data;
      if (awaited_results.size() == 0) begin
        $display("%0t: result word %h arrived with nothing expected", $time, data);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("pwm_duty", want.duty, got.duty);
      compare_field("dir_forward", want.dir_fwd, got.dir_fwd);
      compare_field("dir_reverse", want.dir_rev, got.dir_rev);
      compare_field("enabled", want.enabled, got.enabled);
      compare_field("drive_volts", want.drive, got.drive);
    endfunction
  endclass

endpackage

/* tb/pid_angle_controller_pwm_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_angle_controller_pwm_top_test
// Self-checking bench for the PID angle controller: directed and random
// encoder words under several register settings, checked against a
// word-accurate tracker of the controller state.
// ----------------------------------------------------------------------------
module pid_angle_controller_pwm_top_test;

  import pidpwm_pkg::*;
  import pidpwm_check_pkg::*;

  // The slowest word is a random send gap, the full sequence of work and a
  // random output stall, so this bound leaves a wide margin.
  localparam int CYCLE_LIMIT     = 250000;
  localparam int LATENCY_SLACK   = 24;
  localparam int PHASES          = 9;
  localparam int WORDS_PER_PHASE = 115;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] encoder_count
  logic        in_tuser;   // [0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [9:0] duty, [10] fwd, [11] rev, [12] enabled,
                           // [32:13] drive_volts
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  pid_drive_tracker sb;
  bit in_idle;
  bit out_idle;
  int cycle_count;

  pid_angle_controller_pwm_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pid_angle_controller_pwm_top verification failed");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any update of that edge
  // lands, so the tracker sees exactly what the block sees.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_word(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata);
    end
  end

  // Result side: before each word, when out_idle is set, the receiver may hold
  // off ready for a random stall, then keeps it high until a word is taken.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Offer one input word and return at the edge where it is taken. Valid is
  // left high, so back-to-back words keep it up without a dip.
  task automatic send_word(input logic func, input logic [15:0] count);
    int gap;
    gap = in_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= count;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Write every register, plus a junk write to the unused index that the
  // block has to drop. Only called while the block is idle.
  task automatic program_regs(input cfg_t s);
    put_reg(REG_KP, s.kp);
    put_reg(REG_KI, s.ki);
    put_reg(REG_KD, s.kd);
    put_reg(REG_ILIM, s.ilim);
    put_reg(REG_ALIM, {2'b00, s.alim});
    put_reg(REG_ZERO, s.zero);
    put_reg(REG_AREF, {s.aref[14], s.aref});
    put_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Settings per phase: first the reset defaults, then the upper and lower
  // extremes, a mixed corner, and random settings after that.
  function automatic cfg_t pick_settings(int phase);
    cfg_t s;
    int   aref_val;
    s = sb.regs;
    case (phase)
      0: ;
      1: s = '{kp: 16'hFFFF, ki: 16'hFFFF, kd: 16'hFFFF, ilim: 16'd49152,
               alim: 14'd12868, zero: 16'hFFFF, aref: 15'sd12868};
      2: s = '{kp: 16'd0, ki: 16'd0, kd: 16'd0, ilim: 16'd0,
               alim: 14'd0, zero: 16'd0, aref: -15'sd12868};
      3: s = '{kp: 16'd0, ki: 16'hFFFF, kd: 16'd0, ilim: 16'd49152,
               alim: 14'd12868, zero: 16'd0, aref: -15'sd12868};
      default: begin
        s.kp   = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 4095));
        s.ki   = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 1023));
        s.kd   = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 4095));
        s.ilim = 16'($urandom_range(0, 49152));
        s.alim = 14'($urandom_range(256, 12868));
        s.zero = 16'($urandom_range(0, 65535));
        aref_val = int'($urandom_range(0, 25736)) - 12868;
        s.aref = 15'(aref_val);
      end
    endcase
    return s;
  endfunction

  // About half are ticks whose angle falls inside or just around the
  // safe window, with start requests to re-arm a tripped controller and a
  // share of start words and raw counts at random.
  task automatic send_random();
    int pick, window, shift, count_val;
    pick   = $urandom_range(0, 99);
    window = int'(sb.regs.alim) * 2048 / 6588 + 2;
    shift  = $urandom_range(0, 1) ? int'($signed(sb.regs.aref)) * 2048 / 6588 : 0;
    if (pick < 6 || (!sb.enable_flag && pick < 40)) begin
      send_word(FUNC_START, 16'($urandom));
    end else if (pick < 52) begin
      send_word(FUNC_TICK, 16'($urandom));
    end else begin
      count_val = int'(sb.regs.zero) + shift + int'($urandom_range(0, 2 * window)) - window;
      if (count_val < 0) count_val = 0;
      if (count_val > 65535) count_val = 65535;
      send_word(FUNC_TICK, 16'(count_val));
    end
  endtask

  // Directed words under the reset settings: a tick while disabled, start
  // requests (also back to back, and with a nonzero held drive), both edges
  // of the safe angle window, both saturation directions with a capped duty,
  // small drives of either sign and the extreme counts.
  task automatic run_directed();
    send_word(FUNC_TICK, ZERO_RST);
    send_word(FUNC_START, 16'hFFFF);
    send_word(FUNC_TICK, ZERO_RST);
    send_word(FUNC_TICK, ZERO_RST + 16'd1909);
    send_word(FUNC_TICK, ZERO_RST - 16'd1909);
    send_word(FUNC_TICK, ZERO_RST + 16'd10);
    send_word(FUNC_TICK, ZERO_RST - 16'd10);
    send_word(FUNC_TICK, ZERO_RST + 16'd1910);
    send_word(FUNC_TICK, ZERO_RST);
    send_word(FUNC_START, 16'h0000);
    send_word(FUNC_START, 16'h5A5A);
    send_word(FUNC_TICK, ZERO_RST - 16'd1910);
    send_word(FUNC_START, 16'hA5A5);
    send_word(FUNC_TICK, ZERO_RST + 16'd300);
    send_word(FUNC_START, 16'h00FF);
    send_word(FUNC_TICK, ZERO_RST + 16'd300);
    send_word(FUNC_TICK, 16'h0000);
    send_word(FUNC_START, 16'hFF00);
    send_word(FUNC_TICK, 16'hFFFF);
    send_word(FUNC_START, 16'h1234);
    send_word(FUNC_TICK, ZERO_RST + 16'd1);
    send_word(FUNC_TICK, ZERO_RST - 16'd1);
  endtask

  initial begin
    cfg_t settings;
    sb          = new();
    cycle_count = 0;
    in_idle     = 1'b1;
    out_idle    = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KP;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int phase = 0; phase < PHASES; phase++) begin
      // Registers only change with the pipeline empty.
      drain_results();
      settings = pick_settings(phase);
      if (phase > 0) begin
        program_regs(settings);
      end
      // Rotate through idling on both sides, one side only, and none.
      case (phase % 4)
        0: begin in_idle = 1'b1; out_idle = 1'b1; end
        1: begin in_idle = 1'b1; out_idle = 1'b0; end
        2: begin in_idle = 1'b0; out_idle = 1'b1; end
        default: begin in_idle = 1'b0; out_idle = 1'b0; end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Halfway through, let the block run completely dry once.
        if (n == WORDS_PER_PHASE / 2) begin
          drain_results();
        end
        send_random();
      end
    end

    drain_results();
    repeat (LATENCY_SLACK) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pid_angle_controller_pwm_top verification clean");
    end else begin
      $display("pid_angle_controller_pwm_top verification failed");
    end
    $finish;
  end

endmodule
